// ===== hw/rtl/ooktx_pkg.sv =====
`timescale 1ns / 1ps

package ooktx_pkg;

    localparam int MESSAGE_BYTES = 10;
    localparam int ADDRESS_BYTES = 5;
    localparam int NIBBLE_BITS   = 4;
    localparam int RAW_BITS      = MESSAGE_BYTES * NIBBLE_BITS;
    localparam int ADDR_BITS     = ADDRESS_BYTES * NIBBLE_BITS;
    localparam int CFG_DATA_BITS = ADDR_BITS;
    localparam int CFG_INDEX_BITS = 3;

    // Input opcodes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_CMD  = 2'd1;
    localparam logic [1:0] OP_RAW  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_TOTAL    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INVERT_OUTPUT   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ZERO_TICKS      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGH_TICKS      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRAIL_TICKS     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAP_TICKS       = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAP_EXTRA       = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ADDRESS_NIBBLES = 3'd7;

    // Work kinds handed from the front to the back
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_TICK = 2'd0;
    localparam kind_t KIND_LOAD = 2'd1;
    localparam kind_t KIND_NOP  = 2'd2;

    typedef struct packed {
        kind_t                 kind;
        logic [RAW_BITS-1:0]   nibbles;
    } work_t;

    typedef struct packed {
        logic [5:0]            repeat_total;
        logic                  invert_output;
        logic [7:0]            zero_ticks;
        logic [7:0]            high_ticks;
        logic [7:0]            trail_ticks;
        logic [7:0]            gap_ticks;
        logic [7:0]            gap_extra;
        logic [ADDR_BITS-1:0]  address_nibbles;
    } cfg_t;

    function automatic logic [7:0] code_of(input logic [NIBBLE_BITS-1:0] nib);
        logic [7:0] c;
        unique case (nib)
            4'h0: c = 8'hF6;
            4'h1: c = 8'hEE;
            4'h2: c = 8'hED;
            4'h3: c = 8'hEB;
            4'h4: c = 8'hDE;
            4'h5: c = 8'hDD;
            4'h6: c = 8'hDB;
            4'h7: c = 8'hBE;
            4'h8: c = 8'hBD;
            4'h9: c = 8'hBB;
            4'hA: c = 8'hB7;
            4'hB: c = 8'h7E;
            4'hC: c = 8'h7D;
            4'hD: c = 8'h7B;
            4'hE: c = 8'h77;
            default: c = 8'h6F;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/ooktx_front.sv =====
`timescale 1ns / 1ps

module ooktx_front (
    input  logic [1:0]                    opcode,
    input  logic [7:0]                    param_byte,
    input  logic [3:0]                    command_code,
    input  logic [3:0]                    room_code,
    input  logic [3:0]                    device_code,
    input  logic [ooktx_pkg::RAW_BITS-1:0]  raw_nibbles,
    input  logic [ooktx_pkg::ADDR_BITS-1:0] address_nibbles,
    output ooktx_pkg::work_t              work
);
    import ooktx_pkg::*;

    logic [RAW_BITS-1:0] cmd_nibbles;

    // Assemble the command message in nibble order: parameter high, parameter
    // low, device, command, five address nibbles, room.
    assign cmd_nibbles = {room_code, address_nibbles, command_code, device_code,
                          param_byte[3:0], param_byte[7:4]};

    always_comb
    begin
        work.nibbles = raw_nibbles;
        unique case (opcode)
            OP_TICK: work.kind = KIND_TICK;
            OP_CMD:
            begin
                work.kind    = KIND_LOAD;
                work.nibbles = cmd_nibbles;
            end
            OP_RAW:  work.kind = KIND_LOAD;
            default: work.kind = KIND_NOP;
        endcase
    end

endmodule

// ===== hw/rtl/ooktx_queue.sv =====
`timescale 1ns / 1ps

module ooktx_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ooktx_pkg::work_t  push_data,
    output logic              full,
    input  logic              pop,
    output ooktx_pkg::work_t  head,
    output logic              empty
);
    import ooktx_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);

    work_t                entry_reg [DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;

    assign full  = (count_reg == CNT_BITS'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/ooktx_back.sv =====
`timescale 1ns / 1ps

module ooktx_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ooktx_pkg::cfg_t   cfg,
    input  ooktx_pkg::work_t  head,
    input  logic              empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              pin_level,
    output logic              busy_res
);
    import ooktx_pkg::*;

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_MSG_START  = 3'd1;
    localparam logic [2:0] PH_BYTE_START = 3'd2;
    localparam logic [2:0] PH_SEND_BIT   = 3'd3;
    localparam logic [2:0] PH_MSG_END    = 3'd4;
    localparam logic [2:0] PH_GAP_SEG    = 3'd5;
    localparam logic [2:0] PH_GAP_END    = 3'd6;

    logic [7:0] store_reg [MESSAGE_BYTES];
    logic [7:0] store_next [MESSAGE_BYTES];
    logic [2:0] phase_reg, phase_next;
    logic [7:0] counter_reg, counter_next;
    logic [3:0] byte_idx_reg, byte_idx_next;
    logic [2:0] bit_pos_reg, bit_pos_next;
    logic [5:0] repeat_reg, repeat_next;
    logic [7:0] gap_left_reg, gap_left_next;
    logic       active_reg, active_next;
    logic       pin_reg, pin_next;
    logic       out_valid_reg, out_valid_next;
    logic       pin_level_reg, busy_reg;

    logic [7:0] counter_dec;
    logic [7:0] cur_byte;
    logic [3:0] byte_idx_inc;
    logic [5:0] repeat_inc;

    assign pop       = !empty && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign pin_level = pin_level_reg;
    assign busy_res  = busy_reg;

    assign counter_dec  = counter_reg - 8'd1;
    assign byte_idx_inc = byte_idx_reg + 4'd1;
    assign repeat_inc   = repeat_reg + 6'd1;
    assign cur_byte     = (byte_idx_reg < 4'(MESSAGE_BYTES)) ? store_reg[byte_idx_reg] : 8'h00;

    always_comb
    begin
        store_next    = store_reg;
        phase_next    = phase_reg;
        counter_next  = counter_reg;
        byte_idx_next = byte_idx_reg;
        bit_pos_next  = bit_pos_reg;
        repeat_next   = repeat_reg;
        gap_left_next = gap_left_reg;
        active_next   = active_reg;
        pin_next      = pin_reg;

        if (pop && head.kind == KIND_LOAD)
        begin
            for (int i = 0; i < MESSAGE_BYTES; i++)
            begin
                store_next[i] = code_of(head.nibbles[i*NIBBLE_BITS +: NIBBLE_BITS]);
            end
            active_next = 1'b1;
        end
        else if (pop && head.kind == KIND_TICK && !(phase_reg == PH_IDLE && !active_reg))
        begin
            counter_next = counter_dec;
            if (counter_dec == cfg.trail_ticks)
            begin
                pin_next = 1'b0;
            end
            else if (counter_dec == 8'd0)
            begin
                counter_next = cfg.high_ticks;
                unique case (phase_reg)
                    PH_MSG_START:
                    begin
                        pin_next      = 1'b1;
                        byte_idx_next = 4'd0;
                        phase_next    = PH_BYTE_START;
                    end
                    PH_BYTE_START:
                    begin
                        pin_next     = 1'b1;
                        bit_pos_next = 3'd7;
                        phase_next   = PH_SEND_BIT;
                    end
                    PH_SEND_BIT:
                    begin
                        if (cur_byte[bit_pos_reg])
                        begin
                            pin_next = 1'b1;
                        end
                        else
                        begin
                            counter_next = cfg.zero_ticks;
                        end
                        if (bit_pos_reg == 3'd0)
                        begin
                            byte_idx_next = byte_idx_inc;
                            phase_next = (byte_idx_inc >= 4'(MESSAGE_BYTES)) ?
                                         PH_MSG_END : PH_BYTE_START;
                        end
                        else
                        begin
                            bit_pos_next = bit_pos_reg - 3'd1;
                        end
                    end
                    PH_MSG_END:
                    begin
                        pin_next      = 1'b1;
                        gap_left_next = cfg.gap_extra;
                        phase_next    = PH_GAP_SEG;
                    end
                    PH_GAP_SEG:
                    begin
                        counter_next = cfg.gap_ticks;
                        if (gap_left_reg == 8'd0)
                        begin
                            phase_next = PH_GAP_END;
                        end
                        else
                        begin
                            gap_left_next = gap_left_reg - 8'd1;
                        end
                    end
                    PH_GAP_END:
                    begin
                        repeat_next = repeat_inc;
                        if (repeat_inc >= cfg.repeat_total)
                        begin
                            active_next = 1'b0;
                            phase_next  = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_MSG_START;
                        end
                    end
                    default:
                    begin
                        if (active_reg)
                        begin
                            repeat_next = 6'd0;
                            phase_next  = PH_MSG_START;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                endcase
            end
        end

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MESSAGE_BYTES; i++)
            begin
                store_reg[i] <= 8'h00;
            end
            phase_reg     <= PH_IDLE;
            counter_reg   <= 8'd0;
            byte_idx_reg  <= 4'd0;
            bit_pos_reg   <= 3'd7;
            repeat_reg    <= 6'd0;
            gap_left_reg  <= 8'd0;
            active_reg    <= 1'b0;
            pin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            store_reg     <= store_next;
            phase_reg     <= phase_next;
            counter_reg   <= counter_next;
            byte_idx_reg  <= byte_idx_next;
            bit_pos_reg   <= bit_pos_next;
            repeat_reg    <= repeat_next;
            gap_left_reg  <= gap_left_next;
            active_reg    <= active_next;
            pin_reg       <= pin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pin_level_reg <= pin_next ^ cfg.invert_output;
            busy_reg      <= active_next;
        end
    end

endmodule

// ===== hw/rtl/ook_pulse_message_transmitter.sv =====
`timescale 1ns / 1ps

// On-off-keyed pulse transmitter for a ten-byte radio message. Each input
// transaction is a tick (opcode 0), a command message (opcode 1: parameter,
// device, command and room nibbles plus the five address nibbles of the
// address register) or a raw message of ten nibbles (opcode 2); opcode 3 does
// nothing. Every message nibble is coded to a byte through a fixed table and
// loading a message starts, or restarts in place, a transmission of
// repeat_total copies. Ticks step the pulse machine: start pulse, all bytes
// MSB first, end pulse, gap segments. Every input transaction yields exactly
// one output transaction with the pin level and the busy flag after it.
// Rate: one transaction per clock sustained while the output is not stalled;
// the pulse machine executes one transaction per cycle and a two-entry queue
// sits between the decode front and the machine, so a stalled output does
// not stall input until the queue fills. An accepted input is written into
// the queue, popped by the machine after any work queued ahead of it, and
// its result is then registered.
// Configuration is taken on any cycle (cfg_ready is tied high) and must only
// be written while no transaction is in flight.

module ook_pulse_message_transmitter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ooktx_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ooktx_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          opcode,
    input  logic [7:0]                          param_byte,
    input  logic [3:0]                          command_code,
    input  logic [3:0]                          room_code,
    input  logic [3:0]                          device_code,
    input  logic [ooktx_pkg::RAW_BITS-1:0]       raw_nibbles,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                pin_level,
    output logic                                busy_res
);
    import ooktx_pkg::*;

    cfg_t  cfg_reg;
    work_t front_work;
    work_t queue_head;
    logic  queue_full;
    logic  queue_empty;
    logic  queue_pop;
    logic  in_fire;

    assign cfg_ready = 1'b1;
    assign in_stall  = queue_full;
    assign in_fire   = in_valid && !queue_full;

    // Configuration registers, reset to their documented defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repeat_total    <= 6'd10;
            cfg_reg.invert_output   <= 1'b0;
            cfg_reg.zero_ticks      <= 8'd7;
            cfg_reg.high_ticks      <= 8'd4;
            cfg_reg.trail_ticks     <= 8'd2;
            cfg_reg.gap_ticks       <= 8'd72;
            cfg_reg.gap_extra       <= 8'd0;
            cfg_reg.address_nibbles <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_REPEAT_TOTAL:    cfg_reg.repeat_total    <= cfg_data[5:0];
                CFG_INVERT_OUTPUT:   cfg_reg.invert_output   <= cfg_data[0];
                CFG_ZERO_TICKS:      cfg_reg.zero_ticks      <= cfg_data[7:0];
                CFG_HIGH_TICKS:      cfg_reg.high_ticks      <= cfg_data[7:0];
                CFG_TRAIL_TICKS:     cfg_reg.trail_ticks     <= cfg_data[7:0];
                CFG_GAP_TICKS:       cfg_reg.gap_ticks       <= cfg_data[7:0];
                CFG_GAP_EXTRA:       cfg_reg.gap_extra       <= cfg_data[7:0];
                default:             cfg_reg.address_nibbles <= cfg_data;
            endcase
        end
    end

    // Decode: classify the transaction and assemble message nibbles.
    ooktx_front u_front (
        .opcode          (opcode),
        .param_byte      (param_byte),
        .command_code    (command_code),
        .room_code       (room_code),
        .device_code     (device_code),
        .raw_nibbles     (raw_nibbles),
        .address_nibbles (cfg_reg.address_nibbles),
        .work            (front_work)
    );

    // Hold decoded work until the pulse machine can take it.
    ooktx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_data (front_work),
        .full      (queue_full),
        .pop       (queue_pop),
        .head      (queue_head),
        .empty     (queue_empty)
    );

    // Pulse machine, message store and registered result.
    ooktx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (queue_head),
        .empty     (queue_empty),
        .pop       (queue_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pin_level (pin_level),
        .busy_res  (busy_res)
    );

endmodule

// ===== test/ook_pulse_message_transmitter_checker.sv =====
`timescale 1ns / 1ps

module ook_pulse_message_transmitter_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [ooktx_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ooktx_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic [1:0]                           opcode,
    input  logic [7:0]                           param_byte,
    input  logic [3:0]                           command_code,
    input  logic [3:0]                           room_code,
    input  logic [3:0]                           device_code,
    input  logic [ooktx_pkg::RAW_BITS-1:0]       raw_nibbles,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic                                 pin_level,
    input  logic                                 busy_res,
    output int                                   fail_count,
    output int                                   pending_results
);
    import ooktx_pkg::*;

    typedef enum logic [2:0] {
        TX_IDLE,
        TX_MSG_START,
        TX_BYTE_START,
        TX_SEND_BIT,
        TX_MSG_END,
        TX_GAP_SEG,
        TX_GAP_END
    } pulse_phase_e;

    typedef struct packed {
        logic pin;
        logic busy;
    } line_status_t;

    // Nibble to line code, entry 0 in the low byte.
    localparam logic [127:0] NIBBLE_CODES = {
        8'h6F, 8'h77, 8'h7B, 8'h7D, 8'h7E, 8'hB7, 8'hBB, 8'hBD,
        8'hBE, 8'hDB, 8'hDD, 8'hDE, 8'hEB, 8'hED, 8'hEE, 8'hF6
    };

    cfg_t         regs;
    logic [7:0]   message [MESSAGE_BYTES];
    pulse_phase_e pulse_phase;
    logic [7:0]   tick_count;
    logic [3:0]   byte_idx;
    logic [2:0]   bit_pos;
    logic [5:0]   sent_copies;
    logic [7:0]   gaps_left;
    logic         busy_flag;
    logic         pin_on;

    line_status_t line_status_q[$];
    int           mismatches = 0;
    int           queued = 0;

    assign fail_count      = mismatches;
    assign pending_results = queued;

    function automatic logic [7:0] coded(input logic [3:0] nib);
        return NIBBLE_CODES[{nib, 3'b000} +: 8];
    endfunction

    function void load_message(input logic [RAW_BITS-1:0] nibs);
        for (int i = 0; i < MESSAGE_BYTES; i++)
            message[i] = coded(nibs[4*i +: 4]);
        busy_flag = 1'b1;
    endfunction

    function void advance_pulse();
        logic [7:0] cur;
        if (pulse_phase == TX_IDLE && !busy_flag)
            return;
        tick_count = tick_count - 8'd1;
        if (tick_count == regs.trail_ticks) begin
            pin_on = 1'b0;
            return;
        end
        if (tick_count != 8'd0)
            return;
        tick_count = regs.high_ticks;
        case (pulse_phase)
            TX_MSG_START: begin
                pin_on      = 1'b1;
                byte_idx    = 4'd0;
                pulse_phase = TX_BYTE_START;
            end
            TX_BYTE_START: begin
                pin_on      = 1'b1;
                bit_pos     = 3'd7;
                pulse_phase = TX_SEND_BIT;
            end
            TX_SEND_BIT: begin
                cur = (byte_idx < MESSAGE_BYTES) ? message[byte_idx] : 8'h00;
                if (cur[bit_pos])
                    pin_on = 1'b1;
                else
                    tick_count = regs.zero_ticks;
                if (bit_pos == 3'd0) begin
                    byte_idx = byte_idx + 4'd1;
                    pulse_phase = (byte_idx >= MESSAGE_BYTES) ? TX_MSG_END : TX_BYTE_START;
                end else begin
                    bit_pos = bit_pos - 3'd1;
                end
            end
            TX_MSG_END: begin
                pin_on      = 1'b1;
                gaps_left   = regs.gap_extra;
                pulse_phase = TX_GAP_SEG;
            end
            TX_GAP_SEG: begin
                tick_count = regs.gap_ticks;
                if (gaps_left == 8'd0)
                    pulse_phase = TX_GAP_END;
                else
                    gaps_left = gaps_left - 8'd1;
            end
            TX_GAP_END: begin
                sent_copies = sent_copies + 6'd1;
                if (sent_copies >= regs.repeat_total) begin
                    busy_flag   = 1'b0;
                    pulse_phase = TX_IDLE;
                end else begin
                    pulse_phase = TX_MSG_START;
                end
            end
            default: begin
                if (busy_flag) begin
                    sent_copies = 6'd0;
                    pulse_phase = TX_MSG_START;
                end else begin
                    pulse_phase = TX_IDLE;
                end
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        line_status_t want;
        if (!rst_n) begin
            regs.repeat_total    = 6'd10;
            regs.invert_output   = 1'b0;
            regs.zero_ticks      = 8'd7;
            regs.high_ticks      = 8'd4;
            regs.trail_ticks     = 8'd2;
            regs.gap_ticks       = 8'd72;
            regs.gap_extra       = 8'd0;
            regs.address_nibbles = '0;
            for (int i = 0; i < MESSAGE_BYTES; i++)
                message[i] = 8'h00;
            pulse_phase = TX_IDLE;
            tick_count  = 8'd0;
            byte_idx    = 4'd0;
            bit_pos     = 3'd7;
            sent_copies = 6'd0;
            gaps_left   = 8'd0;
            busy_flag   = 1'b0;
            pin_on      = 1'b0;
            line_status_q.delete();
            queued <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_REPEAT_TOTAL:    regs.repeat_total    = cfg_data[5:0];
                    CFG_INVERT_OUTPUT:   regs.invert_output   = cfg_data[0];
                    CFG_ZERO_TICKS:      regs.zero_ticks      = cfg_data[7:0];
                    CFG_HIGH_TICKS:      regs.high_ticks      = cfg_data[7:0];
                    CFG_TRAIL_TICKS:     regs.trail_ticks     = cfg_data[7:0];
                    CFG_GAP_TICKS:       regs.gap_ticks       = cfg_data[7:0];
                    CFG_GAP_EXTRA:       regs.gap_extra       = cfg_data[7:0];
                    CFG_ADDRESS_NIBBLES: regs.address_nibbles = cfg_data;
                    default: ;
                endcase
            end

            // Compare against the oldest prediction before queuing a new one.
            if (out_valid && !out_stall) begin
                if (line_status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result: pin_level=%b busy_res=%b",
                                 $time, pin_level, busy_res);
                end else begin
                    want = line_status_q.pop_front();
                    if (pin_level !== want.pin || busy_res !== want.busy) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] mismatch: pin_level exp %b got %b, busy_res exp %b got %b",
                                     $time, want.pin, pin_level, want.busy, busy_res);
                    end
                end
            end

            if (in_valid && !in_stall) begin
                case (opcode)
                    OP_TICK: advance_pulse();
                    OP_CMD:  load_message({room_code, regs.address_nibbles, command_code,
                                           device_code, param_byte[3:0], param_byte[7:4]});
                    OP_RAW:  load_message(raw_nibbles);
                    default: ;
                endcase
                want.pin  = pin_on ^ regs.invert_output;
                want.busy = busy_flag;
                line_status_q.push_back(want);
            end

            queued <= line_status_q.size();
        end
    end

endmodule

// ===== test/ook_pulse_message_transmitter_tb.sv =====
`timescale 1ns / 1ps

module ook_pulse_message_transmitter_tb;

    import ooktx_pkg::*;

    // Opcode 3 is undefined in the block: it must leave every state alone.
    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [1:0]                opcode;
    logic [7:0]                param_byte;
    logic [3:0]                command_code;
    logic [3:0]                room_code;
    logic [3:0]                device_code;
    logic [RAW_BITS-1:0]       raw_nibbles;
    logic                      out_valid;
    logic                      out_stall;
    logic                      pin_level;
    logic                      busy_res;

    int   fail_count;
    int   pending_results;
    int   cycle_count = 0;
    // Set while a stretch with no idling on either side is running.
    logic calm;

    ook_pulse_message_transmitter dut (.*);

    ook_pulse_message_transmitter_checker line_checker (.*);

    // 10 ns clock: high half, then low half.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result side at random, at a rate of about 12 percent, except in calm stretches.
    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < 12);
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offer one input transaction, with random idle cycles ahead of it, and
    // hold it until the block takes it. Valid stays high on return so that
    // back-to-back transactions never drop and raise it in the same step.
    task automatic send_item(input logic [1:0] op, input logic [7:0] param,
                             input logic [3:0] cmd, input logic [3:0] room,
                             input logic [3:0] dev, input logic [RAW_BITS-1:0] raw);
        while (!calm && $urandom_range(0, 99) < 12) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        param_byte   <= param;
        command_code <= cmd;
        room_code    <= room;
        device_code  <= dev;
        raw_nibbles  <= raw;
        do @(posedge clk); while (in_stall);
    endtask

    // Random mix: mostly ticks, a few message loads (per mille), a sprinkle of
    // the undefined opcode. Payload bits are random on every transaction.
    task automatic run_phase(input int items, input int send_per_mille);
        int         pick;
        logic [1:0] op;
        logic [63:0] wide;
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(0, 999);
            if (pick < send_per_mille)
                op = pick[0] ? OP_CMD : OP_RAW;
            else if (pick < send_per_mille + 20)
                op = OP_SPARE;
            else
                op = OP_TICK;
            wide = {$urandom, $urandom};
            send_item(op, wide[47:40], wide[51:48], wide[55:52], wide[59:56],
                      wide[RAW_BITS-1:0]);
        end
    endtask

    // Drop valid and hold off until every predicted result has come back,
    // then let the pipeline settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Reprogram every register, after draining the block.
    task automatic program_regs(input logic [5:0] repeats, input logic invert,
                                input logic [7:0] zero_len, input logic [7:0] high_len,
                                input logic [7:0] trail_at, input logic [7:0] gap_len,
                                input logic [7:0] gap_more,
                                input logic [CFG_DATA_BITS-1:0] address);
        drain();
        write_reg(CFG_REPEAT_TOTAL, CFG_DATA_BITS'(repeats));
        write_reg(CFG_INVERT_OUTPUT, CFG_DATA_BITS'(invert));
        write_reg(CFG_ZERO_TICKS, CFG_DATA_BITS'(zero_len));
        write_reg(CFG_HIGH_TICKS, CFG_DATA_BITS'(high_len));
        write_reg(CFG_TRAIL_TICKS, CFG_DATA_BITS'(trail_at));
        write_reg(CFG_GAP_TICKS, CFG_DATA_BITS'(gap_len));
        write_reg(CFG_GAP_EXTRA, CFG_DATA_BITS'(gap_more));
        write_reg(CFG_ADDRESS_NIBBLES, address);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        opcode       = OP_TICK;
        param_byte   = '0;
        command_code = '0;
        room_code    = '0;
        device_code  = '0;
        raw_nibbles  = '0;
        calm         = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset register values.
        // Idle tick and undefined opcode before anything was loaded.
        send_item(OP_TICK, 8'h00, 4'h0, 4'h0, 4'h0, '0);
        send_item(OP_SPARE, 8'hFF, 4'hF, 4'hF, 4'hF, '1);
        // Command message with the lowest fields, then a few ticks.
        send_item(OP_CMD, 8'h00, 4'h0, 4'h0, 4'h0, '0);
        run_phase(3, 0);
        // Reload while busy: highest fields, then raw extremes.
        send_item(OP_CMD, 8'hFF, 4'hF, 4'hF, 4'hF, '0);
        send_item(OP_RAW, 8'h00, 4'h0, 4'h0, 4'h0, '0);
        send_item(OP_RAW, 8'hFF, 4'hF, 4'hF, 4'hF, '1);
        send_item(OP_SPARE, 8'h00, 4'h0, 4'h0, 4'h0, '0);
        run_phase(12, 0);

        // Fast pulse timing with single copies, so messages run to idle.
        program_regs(6'd1, 1'b0, 8'd3, 8'd2, 8'd1, 8'd2, 8'd0,
                     CFG_DATA_BITS'($urandom_range(0, 20'hFFFFF)));
        run_phase(300, 4);

        // Top of every range but the repeat count, which is zero and acts as one copy.
        program_regs(6'd0, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 20'hFFFFF);
        run_phase(100, 10);

        // Two copies with extra gap segments, inverted pin.
        program_regs(6'd2, 1'b1, 8'd4, 8'd2, 8'd1, 8'd3, 8'd2,
                     CFG_DATA_BITS'($urandom_range(0, 20'hFFFFF)));
        run_phase(400, 3);

        // Bottom of every range but the repeat count (63): zero trail count parks the pulse machine, counts wrap.
        program_regs(6'd63, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 20'h00000);
        run_phase(80, 10);

        // Calm stretch: neither side idles.
        program_regs(6'd3, 1'b0, 8'd2, 8'd1, 8'd1, 8'd1, 8'd1,
                     CFG_DATA_BITS'($urandom_range(0, 20'hFFFFF)));
        calm <= 1'b1;
        run_phase(350, 3);
        calm <= 1'b0;

        // Random short timings.
        program_regs(6'($urandom_range(1, 4)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(1, 6)), 8'($urandom_range(1, 4)),
                     8'($urandom_range(1, 3)), 8'($urandom_range(1, 6)),
                     8'($urandom_range(0, 3)),
                     CFG_DATA_BITS'($urandom_range(0, 20'hFFFFF)));
        run_phase(300, 3);

        // Upper end of the usual repeat range.
        program_regs(6'd39, 1'b0, 8'd7, 8'd4, 8'd2, 8'd72, 8'd0,
                     CFG_DATA_BITS'($urandom_range(0, 20'hFFFFF)));
        run_phase(100, 10);

        drain();
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ooktx_pkg.sv
hw/rtl/ooktx_front.sv
hw/rtl/ooktx_queue.sv
hw/rtl/ooktx_back.sv
hw/rtl/ook_pulse_message_transmitter.sv
test/ook_pulse_message_transmitter_checker.sv
test/ook_pulse_message_transmitter_tb.sv
